// ===== rtl/core/imush_pkg.sv =====
package imush_pkg;

    localparam int ACCEL_RAW_W = 16;
    localparam int GYRO_RAW_W  = 16;
    localparam int MAG_RAW_W   = 13;
    localparam int ACCEL_W     = 19;
    localparam int RATE_W      = 19;
    localparam int FIELD_W     = 24;
    localparam int HEAD_W      = 16;
    localparam int GAIN_W      = 11;
    localparam int RANGE_W     = 2;
    localparam int GAIN_SEL_W  = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    // tdata widths, padded to whole bytes
    localparam int IN_DATA_W   = 136;
    localparam int OUT_DATA_W  = 208;

    // gyro: (raw << range) * 250 >>> 8
    localparam int GYRO_SH_W   = 19;
    localparam int GYRO_PROD_W = 27;
    localparam int GYRO_SCALE  = 250;
    localparam int GYRO_SHIFT  = 8;

    localparam int CORDIC_W          = 32;
    localparam int ANGLE_W           = 32;
    localparam int CORDIC_PRESHIFT   = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STEPS_DEF  = 16;

    localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_ROUND = 32'h0000_8000;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_RANGE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GYRO_RANGE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAG_GAIN    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECLINATION = 2'd3;

    localparam logic [RANGE_W-1:0]    ACCEL_RANGE_RST = 2'd0;
    localparam logic [RANGE_W-1:0]    GYRO_RANGE_RST  = 2'd0;
    localparam logic [GAIN_SEL_W-1:0] MAG_GAIN_RST    = 3'd1;
    localparam logic [HEAD_W-1:0]     DECLINATION_RST = 16'd3853;

    // Q8 mG per LSB
    localparam logic [GAIN_W-1:0] MAG_Q8 [8] = '{
        11'd187, 11'd236, 11'd312, 11'd389, 11'd581, 11'd655, 11'd776, 11'd1114
    };

    // atan(2^-i) in 1/2^32 turn
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]  z;
        logic                zero;
    } cordic_t;

    // scaled sensor values riding along the rotation pipeline
    typedef struct packed {
        logic [FIELD_W-1:0] field_z;
        logic [FIELD_W-1:0] field_y;
        logic [FIELD_W-1:0] field_x;
        logic [RATE_W-1:0]  rate_z;
        logic [RATE_W-1:0]  rate_y;
        logic [RATE_W-1:0]  rate_x;
        logic [ACCEL_W-1:0] accel_z;
        logic [ACCEL_W-1:0] accel_y;
        logic [ACCEL_W-1:0] accel_x;
    } side_t;

endpackage

// ===== rtl/core/imush_cordic_stage.sv =====
module imush_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  imush_pkg::cordic_t in_data,
    input  imush_pkg::side_t   in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output imush_pkg::cordic_t out_data,
    output imush_pkg::side_t   out_side
);
    import imush_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    side_t   side_reg;

    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        x_sh = $signed(in_data.x) >>> STEP;
        y_sh = $signed(in_data.y) >>> STEP;
        data_next.zero = in_data.zero;
        // rotate toward y = 0
        if (!in_data.y[CORDIC_W-1])
        begin
            data_next.x = in_data.x + y_sh;
            data_next.y = in_data.y - x_sh;
            data_next.z = in_data.z + ATAN_TURNS[STEP];
        end
        else
        begin
            data_next.x = in_data.x - y_sh;
            data_next.y = in_data.y + x_sh;
            data_next.z = in_data.z - ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/imu_scaling_and_heading.sv =====
// Scales one raw IMU sample set per beat (acceleration in 1/16384 g, angular
// rate in 1/128 deg/s, magnetic field in 1/256 mG) and derives a magnetic
// heading atan2(mag_y, mag_x) plus declination in 1/65536 turn. The path is a
// prep stage (range shifts, gain multiplies, CORDIC setup), one register stage
// per CORDIC_STEPS rotation, and an output register for rounding and
// declination; one beat is taken every cycle while the output is not
// stalled. Ready runs back through the stage valid bits, so bubbles are squeezed
// out while the output is stalled. Configuration writes are registered.
module imu_scaling_and_heading #(
    parameter int CORDIC_STEPS = imush_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [imush_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [imush_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw,
    // gyro_z_raw, mag_x_raw, mag_y_raw, mag_z_raw, zero pad
    input  logic [imush_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // accel_x_g, accel_y_g, accel_z_g, rate_x_dps, rate_y_dps, rate_z_dps,
    // field_x_mg, field_y_mg, field_z_mg, heading_turns, zero pad
    output logic [imush_pkg::OUT_DATA_W-1:0] m_tdata
);
    import imush_pkg::*;

    localparam int GYRO_OFS = 3 * ACCEL_RAW_W;
    localparam int MAG_OFS  = GYRO_OFS + 3 * GYRO_RAW_W;
    localparam int PAD_W    = OUT_DATA_W - $bits(side_t) - HEAD_W;

    logic [RANGE_W-1:0]    accel_range_reg;
    logic [RANGE_W-1:0]    gyro_range_reg;
    logic [GAIN_SEL_W-1:0] mag_gain_reg;
    logic [HEAD_W-1:0]     declination_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_range_reg <= ACCEL_RANGE_RST;
            gyro_range_reg  <= GYRO_RANGE_RST;
            mag_gain_reg    <= MAG_GAIN_RST;
            declination_reg <= DECLINATION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ACCEL_RANGE: accel_range_reg <= cfg_wdata[RANGE_W-1:0];
                CFG_GYRO_RANGE:  gyro_range_reg  <= cfg_wdata[RANGE_W-1:0];
                CFG_MAG_GAIN:    mag_gain_reg    <= cfg_wdata[GAIN_SEL_W-1:0];
                CFG_DECLINATION: declination_reg <= cfg_wdata[HEAD_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- prep stage ----------------
    logic signed [GYRO_SH_W-1:0]   gyro_sh   [3];
    logic signed [GYRO_PROD_W-1:0] gyro_prod [3];
    logic signed [FIELD_W-1:0]     mag_prod  [3];
    logic [ACCEL_W-1:0]            accel_sc  [3];
    logic [MAG_RAW_W-1:0]          mag_x;
    logic [MAG_RAW_W-1:0]          mag_y;
    logic [CORDIC_W-1:0]           x_init;
    logic [CORDIC_W-1:0]           y_init;
    side_t                         side_next;
    cordic_t                       cordic_next;

    logic    prep_valid_reg;
    side_t   prep_side_reg;
    cordic_t prep_cordic_reg;

    cordic_t stage_data  [CORDIC_STEPS+1];
    side_t   stage_side  [CORDIC_STEPS+1];
    logic    stage_valid [CORDIC_STEPS+1];
    logic    stage_ready [CORDIC_STEPS+1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            accel_sc[k]  = ACCEL_W'($signed(s_tdata[k*ACCEL_RAW_W +: ACCEL_RAW_W]))
                           << accel_range_reg;
            gyro_sh[k]   = GYRO_SH_W'($signed(s_tdata[GYRO_OFS + k*GYRO_RAW_W +: GYRO_RAW_W]))
                           <<< gyro_range_reg;
            gyro_prod[k] = GYRO_PROD_W'(gyro_sh[k]) * $signed(GYRO_PROD_W'(GYRO_SCALE));
            mag_prod[k]  = FIELD_W'($signed(s_tdata[MAG_OFS + k*MAG_RAW_W +: MAG_RAW_W]))
                           * $signed(FIELD_W'(MAG_Q8[mag_gain_reg]));
        end

        side_next.accel_x = accel_sc[0];
        side_next.accel_y = accel_sc[1];
        side_next.accel_z = accel_sc[2];
        side_next.rate_x  = gyro_prod[0][GYRO_PROD_W-1:GYRO_SHIFT];
        side_next.rate_y  = gyro_prod[1][GYRO_PROD_W-1:GYRO_SHIFT];
        side_next.rate_z  = gyro_prod[2][GYRO_PROD_W-1:GYRO_SHIFT];
        side_next.field_x = mag_prod[0];
        side_next.field_y = mag_prod[1];
        side_next.field_z = mag_prod[2];

        mag_x  = s_tdata[MAG_OFS +: MAG_RAW_W];
        mag_y  = s_tdata[MAG_OFS + MAG_RAW_W +: MAG_RAW_W];
        x_init = {{(CORDIC_W-MAG_RAW_W-CORDIC_PRESHIFT){mag_x[MAG_RAW_W-1]}}, mag_x,
                  {CORDIC_PRESHIFT{1'b0}}};
        y_init = {{(CORDIC_W-MAG_RAW_W-CORDIC_PRESHIFT){mag_y[MAG_RAW_W-1]}}, mag_y,
                  {CORDIC_PRESHIFT{1'b0}}};

        // left half plane: flip by half a turn first
        if (mag_x[MAG_RAW_W-1])
        begin
            cordic_next.x = -x_init;
            cordic_next.y = -y_init;
            cordic_next.z = HALF_TURN;
        end
        else
        begin
            cordic_next.x = x_init;
            cordic_next.y = y_init;
            cordic_next.z = '0;
        end
        cordic_next.zero = (mag_x == '0) && (mag_y == '0);
    end

    assign s_tready = !prep_valid_reg || stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            prep_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            prep_side_reg   <= side_next;
            prep_cordic_reg <= cordic_next;
        end
    end

    assign stage_data[0]  = prep_cordic_reg;
    assign stage_side[0]  = prep_side_reg;
    assign stage_valid[0] = prep_valid_reg;

    // ---------------- rotation stages ----------------
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        imush_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .in_side   (stage_side[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1]),
            .out_side  (stage_side[i+1])
        );
    end

    // ---------------- output register ----------------
    logic               out_valid_reg;
    side_t              out_side_reg;
    logic [HEAD_W-1:0]  out_heading_reg;
    logic [HEAD_W-1:0]  heading_next;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] angle_rnd;

    always_comb
    begin
        angle        = stage_data[CORDIC_STEPS].zero ? '0 : stage_data[CORDIC_STEPS].z;
        angle_rnd    = angle + ANGLE_ROUND;
        heading_next = angle_rnd[ANGLE_W-1 -: HEAD_W] + declination_reg;
    end

    assign stage_ready[CORDIC_STEPS] = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_ready[CORDIC_STEPS])
        begin
            out_valid_reg <= stage_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[CORDIC_STEPS] && stage_valid[CORDIC_STEPS])
        begin
            out_side_reg    <= stage_side[CORDIC_STEPS];
            out_heading_reg <= heading_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_heading_reg, out_side_reg};

endmodule

// ===== sim/imu_scaling_and_heading_chk.sv =====
`timescale 1ns / 1ps

module imu_scaling_and_heading_chk #(
    parameter int STEPS = imush_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [imush_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [imush_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [imush_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [imush_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                               errors,
    output int                               pending,
    output int                               checked
);
    import imush_pkg::*;

    // atan(2^-i) in 1/2^32 turn
    localparam logic [31:0] ARC_STEP [24] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Q8 mG per LSB
    localparam logic [10:0] GAIN_Q8 [8] = '{
        11'd187, 11'd236, 11'd312, 11'd389, 11'd581, 11'd655, 11'd776, 11'd1114
    };

    logic [1:0]  acc_shift;
    logic [1:0]  gyr_shift;
    logic [2:0]  gain_sel;
    logic [15:0] decl;

    logic [OUT_DATA_W-1:0] due_readings [$];
    logic [OUT_DATA_W-1:0] want;
    int                    mism;
    int                    n_checked;

    function automatic logic [31:0] field_angle(input longint mx, input longint my);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        x = mx * 65536;
        y = my * 65536;
        z = '0;
        if (mx == 0 && my == 0)
            return '0;
        // left half plane: rotate by a half turn first
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += ARC_STEP[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= ARC_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic logic [OUT_DATA_W-1:0] scale_sample(input logic [IN_DATA_W-1:0] d);
        logic [OUT_DATA_W-1:0] r;
        longint                a;
        longint                g;
        longint                m;
        logic [31:0]           ang;
        logic [15:0]           hd;
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            a = longint'($signed(d[16*k +: 16])) * (longint'(1) << acc_shift);
            g = longint'($signed(d[48 + 16*k +: 16])) * (longint'(1) << gyr_shift) * 250;
            g = g >>> 8;
            m = longint'($signed(d[96 + 13*k +: 13])) * longint'(GAIN_Q8[gain_sel]);
            r[19*k +: 19]       = a[18:0];
            r[57 + 19*k +: 19]  = g[18:0];
            r[114 + 24*k +: 24] = m[23:0];
        end
        ang = field_angle(longint'($signed(d[96 +: 13])), longint'($signed(d[109 +: 13])));
        ang = ang + 32'h0000_8000;
        hd = ang[31:16] + decl;
        r[186 +: 16] = hd;
        return r;
    endfunction

    function automatic logic [23:0] out_field(input logic [OUT_DATA_W-1:0] v, input int f);
        int lsb;
        int w;
        if (f < 6)
        begin
            lsb = 19 * f;
            w = 19;
        end
        else if (f < 9)
        begin
            lsb = 114 + 24 * (f - 6);
            w = 24;
        end
        else
        begin
            lsb = 186;
            w = 16;
        end
        return 24'((v >> lsb) & ((OUT_DATA_W'(1) << w) - 1));
    endfunction

    function automatic string field_name(input int f);
        case (f)
            0: return "accel_x_g";
            1: return "accel_y_g";
            2: return "accel_z_g";
            3: return "rate_x_dps";
            4: return "rate_y_dps";
            5: return "rate_z_dps";
            6: return "field_x_mg";
            7: return "field_y_mg";
            8: return "field_z_mg";
            default: return "heading_turns";
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_shift = 2'd0;
            gyr_shift = 2'd0;
            gain_sel  = 3'd1;
            decl      = 16'd3853;
            due_readings.delete();
            mism      = 0;
            n_checked = 0;
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_ACCEL_RANGE: acc_shift = cfg_wdata[1:0];
                    CFG_GYRO_RANGE:  gyr_shift = cfg_wdata[1:0];
                    CFG_MAG_GAIN:    gain_sel  = cfg_wdata[2:0];
                    CFG_DECLINATION: decl      = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                due_readings.push_back(scale_sample(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (due_readings.size() == 0)
                begin
                    if (mism < 10)
                        $display("[%0t] unexpected result beat %h", $time, m_tdata);
                    mism++;
                end
                else
                begin
                    want = due_readings.pop_front();
                    n_checked++;
                    for (int f = 0; f < 10; f++)
                    begin
                        if (out_field(m_tdata, f) !== out_field(want, f))
                        begin
                            if (mism < 10)
                                $display("[%0t] %s: expected %h got %h", $time,
                                         field_name(f), out_field(want, f),
                                         out_field(m_tdata, f));
                            mism++;
                        end
                    end
                end
            end
            errors  <= mism;
            pending <= due_readings.size();
            checked <= n_checked;
        end
    end

endmodule

// ===== sim/imu_scaling_and_heading_tb.sv =====
`timescale 1ns / 1ps

module imu_scaling_and_heading_tb;
    import imush_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int N_PHASES    = 8;
    localparam int RAND_PER_PH = 75;
    localparam int LIMIT       = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int errors;
    int pending;
    int checked;
    int cycles = 0;
    int sent;
    int tx_gap;
    int rx_gap;

    imu_scaling_and_heading #(.CORDIC_STEPS(STEPS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    imu_scaling_and_heading_chk #(.STEPS(STEPS)) chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_gap);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_sample(
        input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
        input logic [15:0] gx, input logic [15:0] gy, input logic [15:0] gz,
        input logic [12:0] mx, input logic [12:0] my, input logic [12:0] mz);
        return {1'b0, mz, my, mx, gz, gy, gx, az, ay, ax};
    endfunction

    function automatic logic [15:0] raw16();
        case ($urandom_range(11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // magnetometer counts span -4096..2047
    function automatic logic [12:0] raw_mag(input int style);
        case (style)
            0: return 13'd0;
            1: return 13'($urandom_range(16)) - 13'd8;
            2: return ($urandom_range(1) == 1) ? 13'h1000 : 13'h07FF;
            default: return 13'($urandom_range(6143)) - 13'd4096;
        endcase
    endfunction

    task automatic send_sample(input logic [IN_DATA_W-1:0] d);
        while ($urandom_range(99) < tx_gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic write_settings(input logic [15:0] acc, input logic [15:0] gyr,
                                  input logic [15:0] gain, input logic [15:0] dcl);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ACCEL_RANGE;
        cfg_wdata <= acc;
        @(posedge clk);
        cfg_addr  <= CFG_GYRO_RANGE;
        cfg_wdata <= gyr;
        @(posedge clk);
        cfg_addr  <= CFG_MAG_GAIN;
        cfg_wdata <= gain;
        @(posedge clk);
        cfg_addr  <= CFG_DECLINATION;
        cfg_wdata <= dcl;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // axis crossings, both half planes, zero field, scale extremes
    task automatic send_corner_cases();
        send_sample(pack_sample('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 13'h07FF, 13'h07FF, 13'h07FF));
        send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 13'h1000, 13'h1000, 13'h1000));
        send_sample(pack_sample(16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'h0001,
                                16'h7FFF, 13'h07FF, 13'h0000, 13'h1FFF));
        send_sample(pack_sample(16'h0001, 16'hFFFF, 16'h7FFF, 16'h0001, 16'hFFFF,
                                16'h8000, 13'h0000, 13'h07FF, 13'h0001));
        send_sample(pack_sample(16'h5555, 16'hAAAA, 16'h0000, 16'hAAAA, 16'h5555,
                                16'h0000, 13'h0000, 13'h1000, 13'h0AAA));
        send_sample(pack_sample(16'hAAAA, 16'h5555, 16'hFFFF, 16'h5555, 16'hAAAA,
                                16'hFFFF, 13'h1000, 13'h0000, 13'h0555));
        send_sample(pack_sample(16'h0002, 16'hFFFE, 16'h4000, 16'hFF00, 16'h0100,
                                16'hC000, 13'h1FFF, 13'h1FFF, 13'h1FFF));
        send_sample(pack_sample(16'hC000, 16'h3FFF, 16'h0080, 16'h0003, 16'hFFFD,
                                16'h0080, 13'h1000, 13'h07FF, 13'h0100));
        send_sample(pack_sample(16'h1234, 16'hEDCB, 16'h7FFE, 16'hFFFE, 16'h0002,
                                16'h8001, 13'h0001, 13'h1FFF, 13'h1F00));
    endtask

    task automatic send_random_sample();
        int xs;
        int ys;
        xs = ($urandom_range(9) == 0) ? $urandom_range(2) : 3;
        ys = ($urandom_range(9) == 0) ? $urandom_range(2) : 3;
        if ($urandom_range(5) == 0)
        begin
            xs = 1;
            ys = 1;
        end
        send_sample(pack_sample(raw16(), raw16(), raw16(), raw16(), raw16(), raw16(),
                                raw_mag(xs), raw_mag(ys), raw_mag($urandom_range(3))));
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        sent      = 0;
        tx_gap    = 26;
        rx_gap    = 62;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p < 3)
            begin
                tx_gap = 26;
                rx_gap <= 62;
            end
            else if (p < 6)
            begin
                tx_gap = 62;
                rx_gap <= 26;
            end
            else
            begin
                tx_gap = 0;
                rx_gap <= 0;
            end
            // phase 0 runs on reset values; upper bits beyond each register are junk
            if (p == 1)
                write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (p == 2)
                write_settings(16'hFFFC, 16'h0004, 16'hFFF8, 16'h0000);
            else if (p > 2)
                write_settings(16'($urandom), 16'($urandom),
                               {13'($urandom), 3'(p - 1)}, 16'($urandom));
            if (p < 2)
                send_corner_cases();
            for (int n = 0; n < RAND_PER_PH; n++)
                send_random_sample();
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end

        // catch any stray beats
        repeat (STEPS + 8) @(posedge clk);
        $display("Sent %0d sample sets over %0d register settings (all gains, range extremes)",
                 sent, N_PHASES);
        $display("Checked %0d results field by field under mixed stalls", checked);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
